// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int CNT_W       = 6;
  localparam int BODY_DEPTH  = 36;
  localparam int BODY_AW     = $clog2(BODY_DEPTH);
  localparam int FID_W       = 4;
  localparam int ST_W        = 3;
  localparam int CFG_AW      = 3;

  localparam logic [CNT_W-1:0] FRAME_BYTES = 6'd41;
  localparam logic [CNT_W-1:0] CRC_POS     = 6'd39;
  localparam logic [CNT_W-1:0] BODY_START  = 6'd5;
  localparam logic [CNT_W-1:0] COUNT_SAT   = 6'd42;

  localparam logic [CNT_W-1:0] POS_MAGIC0  = 6'd0;
  localparam logic [CNT_W-1:0] POS_MAGIC1  = 6'd1;
  localparam logic [CNT_W-1:0] POS_VER     = 6'd2;
  localparam logic [CNT_W-1:0] POS_KIND    = 6'd3;
  localparam logic [CNT_W-1:0] POS_PLEN    = 6'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_LENGTH  = 3'd1;
  localparam logic [ST_W-1:0] ST_MAGIC   = 3'd2;
  localparam logic [ST_W-1:0] ST_VERSION = 3'd3;
  localparam logic [ST_W-1:0] ST_TYPE    = 3'd4;
  localparam logic [ST_W-1:0] ST_PLEN    = 3'd5;
  localparam logic [ST_W-1:0] ST_CRC     = 3'd6;

  localparam logic [CFG_AW-1:0] CFG_MAGIC0 = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_MAGIC1 = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_VER    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KIND   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PLEN   = 3'd4;

  localparam logic [FID_W-1:0] FIELD_LAST = 4'd11;

  typedef struct packed {
    logic take;
    logic capture;
    logic advance;
  } sfd_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic field_done;
    logic out_last;
  } sfd_stat_t;

  // Byte count of each field minus one; fields lie back to back from body byte 0.
  function automatic logic [1:0] field_size_m1(input logic [FID_W-1:0] id);
    logic [1:0] s;
    case (id)
      4'd0:    s = 2'd1;
      4'd1:    s = 2'd1;
      4'd2:    s = 2'd3;
      4'd3:    s = 2'd3;
      4'd4:    s = 2'd1;
      4'd5:    s = 2'd3;
      4'd6:    s = 2'd1;
      4'd7:    s = 2'd3;
      4'd8:    s = 2'd3;
      4'd9:    s = 2'd1;
      4'd10:   s = 2'd0;
      4'd11:   s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hdl/sfd_ram.sv =====
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sfd_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  sfd_stat_t stat,
  output sfd_cmd_t  cmd
);

  localparam logic [1:0] S_RECV = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CAP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       frame_end;

  assign in_tready   = (state_r == S_RECV);
  assign out_tvalid  = (state_r == S_EMIT);
  assign cmd.take    = in_tready && in_tvalid;
  assign cmd.capture = (state_r == S_CAP);
  assign cmd.advance = out_tvalid && out_tready;
  assign frame_end   = cmd.take && in_tlast;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RECV: begin
        if (cmd.take && in_tlast) begin
          state_nxt = stat.frame_ok ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        state_nxt = stat.field_done ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (out_tready) begin
          state_nxt = stat.out_last ? S_RECV : S_READ;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SFD_ASSERT_NXT(a_bad_end, frame_end && !stat.frame_ok, out_tvalid && stat.out_last, "no word")
  `SFD_ASSERT_NXT(a_ok_end, frame_end && stat.frame_ok, state_r == S_READ, "no body read")
  `SFD_ASSERT_NXT(a_field_emits, cmd.capture && stat.field_done, out_tvalid, "no field word")
  `SFD_ASSERT_NXT(a_last_returns, cmd.advance && stat.out_last, in_tready, "frame not closed")

endmodule

// ===== hdl/sfd_datapath.sv =====
`timescale 1ns / 1ps

module sfd_datapath
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [7:0]        cfg_wdata,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  sfd_cmd_t          cmd,
  output sfd_stat_t         stat,
  output logic [ST_W-1:0]   out_status,
  output logic [FID_W-1:0]  out_field_id,
  output logic [31:0]       out_field_value,
  output logic              out_last
);

  logic [7:0] magic0_r, magic1_r, ver_r, kind_r, plen_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic [ST_W-1:0]    fault_r, fault_nxt;
  logic [7:0]         crc_lo_r;
  logic [ST_W-1:0]    code;
  logic [ST_W-1:0]    end_status;
  logic               in_frame;

  logic [BODY_AW-1:0] rd_addr_r;
  logic [FID_W-1:0]   field_r;
  logic [1:0]         bsel_r;
  logic [31:0]        acc_r;
  logic [31:0]        acc_cap;
  logic [7:0]         rd_data;

  logic               wr_en;
  logic [CNT_W-1:0]   wr_off;

  logic [ST_W-1:0]    out_status_r;
  logic [FID_W-1:0]   out_id_r;
  logic [31:0]        out_value_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic0_r <= '0;
      magic1_r <= '0;
      ver_r    <= '0;
      kind_r   <= '0;
      plen_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAGIC0: magic0_r <= cfg_wdata;
        CFG_MAGIC1: magic1_r <= cfg_wdata;
        CFG_VER:    ver_r    <= cfg_wdata;
        CFG_KIND:   kind_r   <= cfg_wdata;
        CFG_PLEN:   plen_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_frame = (count_r < FRAME_BYTES);

  always_comb begin
    code = ST_OK;
    case (count_r)
      POS_MAGIC0: if (in_byte != magic0_r) code = ST_MAGIC;
      POS_MAGIC1: if (in_byte != magic1_r) code = ST_MAGIC;
      POS_VER:    if (in_byte != ver_r)    code = ST_VERSION;
      POS_KIND:   if (in_byte != kind_r)   code = ST_TYPE;
      POS_PLEN:   if (in_byte != plen_r)   code = ST_PLEN;
      default:    code = ST_OK;
    endcase
  end

  always_comb begin
    crc_nxt   = crc_r;
    fault_nxt = fault_r;
    if (in_frame) begin
      if (count_r < CRC_POS) begin
        crc_nxt = crc16_byte(crc_r, in_byte);
      end
      if (fault_r == ST_OK) begin
        fault_nxt = code;
      end
    end
    count_nxt = (count_r < COUNT_SAT) ? count_r + CNT_W'(1) : count_r;

    if (count_nxt != FRAME_BYTES) begin
      end_status = ST_LENGTH;
    end else if (fault_nxt != ST_OK) begin
      end_status = fault_nxt;
    end else if ({in_byte, crc_lo_r} != crc_nxt) begin
      end_status = ST_CRC;
    end else begin
      end_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      fault_r <= ST_OK;
    end else if (cmd.take) begin
      if (in_last) begin
        count_r <= '0;
        crc_r   <= CRC_INIT;
        fault_r <= ST_OK;
      end else begin
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
        fault_r <= fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (count_r == CRC_POS)) begin
      crc_lo_r <= in_byte;
    end
  end

  assign wr_off = count_r - BODY_START;
  assign wr_en  = cmd.take && in_frame && (count_r >= BODY_START);

  sfd_ram #(
    .WIDTH(8),
    .DEPTH(BODY_DEPTH)
  ) u_body (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_off[BODY_AW-1:0]),
    .wdata(in_byte),
    .raddr(rd_addr_r),
    .rdata(rd_data)
  );

  assign acc_cap = acc_r | ({24'h000000, rd_data} << {bsel_r, 3'b000});

  always_ff @(posedge clk) begin
    if (cmd.take && in_last) begin
      rd_addr_r <= '0;
      field_r   <= '0;
      bsel_r    <= '0;
      acc_r     <= '0;
    end else if (cmd.capture) begin
      rd_addr_r <= rd_addr_r + BODY_AW'(1);
      if (stat.field_done) begin
        acc_r  <= acc_cap;
      end else begin
        acc_r  <= acc_cap;
        bsel_r <= bsel_r + 2'd1;
      end
    end else if (cmd.advance) begin
      field_r <= field_r + FID_W'(1);
      bsel_r  <= '0;
      acc_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_last && (end_status != ST_OK)) begin
      out_status_r <= end_status;
      out_id_r     <= '0;
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.capture && stat.field_done) begin
      out_status_r <= ST_OK;
      out_id_r     <= field_r;
      out_value_r  <= acc_cap;
      out_last_r   <= (field_r == FIELD_LAST);
    end
  end

  assign stat.frame_ok   = (end_status == ST_OK);
  assign stat.field_done = (bsel_r == field_size_m1(field_r));
  assign stat.out_last   = out_last_r;

  assign out_status      = out_status_r;
  assign out_field_id    = out_id_r;
  assign out_field_value = out_value_r;
  assign out_last        = out_last_r;

endmodule

// ===== hdl/sensor_frame_decoder_crc16_unit.sv =====
`timescale 1ns / 1ps
// Input: one byte word per cycle while a frame is received; CRC and header checks run per byte.
// Failed frame: the single status word is offered in the cycle after the last byte is taken.
// Good frame: 33 body bytes are read back through the single RAM read port, each via S_READ
// and S_CAP; each field word is offered as it completes; in_tready returns after the last word.
// Reset (rst_n low, synchronous) clears config, count, CRC and fault; body RAM is not cleared.

module sensor_frame_decoder_crc16_unit
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [3:0] field_id, [35:4] field_value, [39:36] zero
  output logic [2:0]        out_tuser,  // [2:0] status
  output logic              out_tlast
);

  sfd_cmd_t          cmd;
  sfd_stat_t         stat;
  logic [FID_W-1:0]  field_id;
  logic [31:0]       field_value;

  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfd_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_byte        (in_tdata),
    .in_last        (in_tlast),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_tuser),
    .out_field_id   (field_id),
    .out_field_value(field_value),
    .out_last       (out_tlast)
  );

  assign out_tdata = {4'b0000, field_value, field_id};

endmodule
